// ===== rtl/smt_pkg.sv =====
// Shared types and constants for the sorted multiset table.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package smt_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 16;
    localparam int POS_W   = 6;
    localparam int DIST_W  = 7;
    localparam int TOTAL_W = 22;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 22'h3FFFFF;
    localparam logic [DIST_W-1:0]  DIST_MAX  = 7'h7F;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_LOOKUP  = 2'd2,
        CMD_READ_AT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_POS   = 2'd3
    } status_t;

    // Datapath operations issued by the controller, one per cycle
    typedef enum logic [3:0] {
        DP_IDLE       = 4'd0,
        DP_LOAD       = 4'd1,
        DP_SCAN       = 4'd2,
        DP_BUMP       = 4'd3,
        DP_ROOM_INIT  = 4'd4,
        DP_ROOM_STEP  = 4'd5,
        DP_PLACE      = 4'd6,
        DP_CLOSE_INIT = 4'd7,
        DP_CLOSE_STEP = 4'd8,
        DP_DROP       = 4'd9,
        DP_READ_POS   = 4'd10,
        DP_RESULT     = 4'd11
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic scan_done;
        logic shift_done;
        logic found;
        logic full;
        logic cnt_one;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/smt_ctrl.sv =====
// Controller state machine of the sorted multiset table.
// Depends on smt_pkg; drives the datapath through dp_ctrl_t.
`default_nettype none

module smt_ctrl
    import smt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire dp_stat_t stat,
    output dp_ctrl_t      ctrl,
    output logic          busy
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_ROOM   = 5'b00100,
        S_CLOSE  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    dp_op_t op;

    always_comb
    begin
        state_next = state_reg;
        op         = DP_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op         = DP_LOAD;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.cmd == CMD_READ_AT)
                begin
                    op         = DP_READ_POS;
                    state_next = S_RESULT;
                end
                else if (!stat.scan_done)
                begin
                    op = DP_SCAN;
                end
                else
                begin
                    state_next = S_RESULT;
                    case (stat.cmd)
                        CMD_ADD:
                        begin
                            if (stat.found)
                            begin
                                op = DP_BUMP;
                            end
                            else if (!stat.full)
                            begin
                                op         = DP_ROOM_INIT;
                                state_next = S_ROOM;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (stat.found && stat.cnt_one)
                            begin
                                op         = DP_CLOSE_INIT;
                                state_next = S_CLOSE;
                            end
                            else if (stat.found)
                            begin
                                op = DP_BUMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ROOM:
            begin
                if (stat.shift_done)
                begin
                    op         = DP_PLACE;
                    state_next = S_RESULT;
                end
                else
                begin
                    op = DP_ROOM_STEP;
                end
            end
            S_CLOSE:
            begin
                if (stat.shift_done)
                begin
                    op         = DP_DROP;
                    state_next = S_RESULT;
                end
                else
                begin
                    op = DP_CLOSE_STEP;
                end
            end
            S_RESULT:
            begin
                op         = DP_RESULT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign ctrl.op = op;
    assign busy    = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/smt_dpath.sv =====
// Datapath of the sorted multiset table: entry memories, scan and shift
// pointers, counters and result registers. Depends on smt_pkg.
`default_nettype none

module smt_dpath
    import smt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dp_ctrl_t                   ctrl,
    output dp_stat_t                        stat,
    input  wire logic [1:0]                 cmd,
    input  wire logic signed [VALUE_W-1:0]  value,
    input  wire logic [POS_W-1:0]           position,
    input  wire logic                       cfg_we,
    input  wire logic                       order_descending,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [COUNT_W-1:0]              occurrences,
    output logic signed [VALUE_W-1:0]       value_out,
    output logic [DIST_W-1:0]               distinct_count,
    output logic [TOTAL_W-1:0]              total_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = COUNT_W + AW;
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int DW = (CW > DIST_W) ? CW : DIST_W;
    localparam int SW = (TW > TOTAL_W) ? TW : TOTAL_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    function automatic logic comes_before(input logic [VALUE_W-1:0] a,
                                          input logic [VALUE_W-1:0] b,
                                          input logic desc);
        logic lt;
        logic gt;
        lt = $signed(a) < $signed(b);
        gt = $signed(a) > $signed(b);
        return desc ? gt : lt;
    endfunction

    // Entry storage
    logic [VALUE_W-1:0] mem_val [DEPTH];
    logic [COUNT_W-1:0] mem_cnt [DEPTH];

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_val;
    logic [COUNT_W-1:0] wr_cnt;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_val_reg;
    logic [COUNT_W-1:0] rd_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_val[wr_addr] <= wr_val;
            mem_cnt[wr_addr] <= wr_cnt;
        end
        if (rd_en)
        begin
            rd_val_reg <= mem_val[rd_addr];
            rd_cnt_reg <= mem_cnt[rd_addr];
        end
    end

    // Control state
    logic          order_reg,     order_next;
    cmd_t          cmd_reg,       cmd_next;
    logic [CW-1:0] used_reg,      used_next;
    logic [TW-1:0] total_reg,     total_next;
    logic [CW-1:0] ptr_reg,       ptr_next;
    logic [CW-1:0] tag_reg,       tag_next;
    logic          rd_vld_reg,    rd_vld_next;
    logic          found_reg,     found_next;
    logic          ins_found_reg, ins_found_next;
    logic          full_reg,      full_next;
    logic          done_reg,      done_next;

    // Payload
    logic [VALUE_W-1:0] val_reg,     val_next;
    logic [POS_W-1:0]   pos_reg,     pos_next;
    logic [CW-1:0]      hit_reg,     hit_next;
    logic [COUNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [CW-1:0]      ins_reg,     ins_next;
    status_t            res_st_reg,  res_st_next;
    logic [COUNT_W-1:0] res_occ_reg, res_occ_next;
    logic [VALUE_W-1:0] res_val_reg, res_val_next;
    logic [DIST_W-1:0]  res_dst_reg, res_dst_next;
    logic [TOTAL_W-1:0] res_tot_reg, res_tot_next;

    logic [CW-1:0]      ptr_dec;
    logic [CW-1:0]      ptr_inc;
    logic [CW-1:0]      tag_inc;
    logic [CW-1:0]      tag_dec;
    logic [COUNT_W-1:0] cnt_inc;
    logic [PW-1:0]      pos_w;
    logic               pos_ok;
    logic [DW-1:0]      used_w;
    logic [SW-1:0]      total_w;

    assign ptr_dec = ptr_reg - 1'b1;
    assign ptr_inc = ptr_reg + 1'b1;
    assign tag_inc = tag_reg + 1'b1;
    assign tag_dec = tag_reg - 1'b1;
    assign cnt_inc = (hit_cnt_reg == COUNT_MAX) ? COUNT_MAX : hit_cnt_reg + 1'b1;
    assign pos_w   = PW'(pos_reg);
    assign pos_ok  = pos_w < PW'(used_reg);
    assign used_w  = DW'(used_reg);
    assign total_w = SW'(total_reg);

    always_comb
    begin
        order_next     = order_reg;
        cmd_next       = cmd_reg;
        used_next      = used_reg;
        total_next     = total_reg;
        ptr_next       = ptr_reg;
        tag_next       = tag_reg;
        rd_vld_next    = 1'b0;
        found_next     = found_reg;
        ins_found_next = ins_found_reg;
        full_next      = full_reg;
        done_next      = 1'b0;
        val_next       = val_reg;
        pos_next       = pos_reg;
        hit_next       = hit_reg;
        hit_cnt_next   = hit_cnt_reg;
        ins_next       = ins_reg;
        res_st_next    = res_st_reg;
        res_occ_next   = res_occ_reg;
        res_val_next   = res_val_reg;
        res_dst_next   = res_dst_reg;
        res_tot_next   = res_tot_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_val         = val_reg;
        wr_cnt         = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        if (cfg_we)
        begin
            order_next = order_descending;
        end

        case (ctrl.op)
            DP_LOAD:
            begin
                cmd_next       = cmd_t'(cmd);
                val_next       = value;
                pos_next       = position;
                ptr_next       = '0;
                found_next     = 1'b0;
                ins_found_next = 1'b0;
                ins_next       = used_reg;
                full_next      = (used_reg >= DEPTH_C);
            end
            DP_SCAN:
            begin
                // read one entry a cycle, compare it the cycle after
                if (!found_reg && (ptr_reg < used_reg))
                begin
                    rd_en       = 1'b1;
                    rd_addr     = ptr_reg[AW-1:0];
                    rd_vld_next = 1'b1;
                    tag_next    = ptr_reg;
                    ptr_next    = ptr_inc;
                end
                if (rd_vld_reg && !found_reg)
                begin
                    if (rd_val_reg == val_reg)
                    begin
                        found_next   = 1'b1;
                        hit_next     = tag_reg;
                        hit_cnt_next = rd_cnt_reg;
                    end
                    if (!ins_found_reg && !comes_before(rd_val_reg, val_reg, order_reg))
                    begin
                        ins_found_next = 1'b1;
                        ins_next       = tag_reg;
                    end
                end
            end
            DP_BUMP:
            begin
                wr_en   = 1'b1;
                wr_addr = hit_reg[AW-1:0];
                if (cmd_reg == CMD_ADD)
                begin
                    wr_cnt = cnt_inc;
                    if (hit_cnt_reg != COUNT_MAX)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                end
                else
                begin
                    wr_cnt     = hit_cnt_reg - 1'b1;
                    total_next = total_reg - 1'b1;
                end
            end
            DP_ROOM_INIT:
            begin
                ptr_next = used_reg;
            end
            DP_ROOM_STEP:
            begin
                // move entries one place back, last first
                if (ptr_reg > ins_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = ptr_dec[AW-1:0];
                    rd_vld_next = 1'b1;
                    tag_next    = ptr_dec;
                    ptr_next    = ptr_dec;
                end
                if (rd_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = tag_inc[AW-1:0];
                    wr_val  = rd_val_reg;
                    wr_cnt  = rd_cnt_reg;
                end
            end
            DP_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = ins_reg[AW-1:0];
                wr_val     = val_reg;
                wr_cnt     = COUNT_W'(1);
                used_next  = used_reg + 1'b1;
                total_next = total_reg + 1'b1;
            end
            DP_CLOSE_INIT:
            begin
                ptr_next = hit_reg + 1'b1;
            end
            DP_CLOSE_STEP:
            begin
                // move later entries one place forward, first first
                if (ptr_reg < used_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = ptr_reg[AW-1:0];
                    rd_vld_next = 1'b1;
                    tag_next    = ptr_reg;
                    ptr_next    = ptr_inc;
                end
                if (rd_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = tag_dec[AW-1:0];
                    wr_val  = rd_val_reg;
                    wr_cnt  = rd_cnt_reg;
                end
            end
            DP_DROP:
            begin
                used_next  = used_reg - 1'b1;
                total_next = total_reg - 1'b1;
            end
            DP_READ_POS:
            begin
                rd_en   = 1'b1;
                rd_addr = pos_w[AW-1:0];
            end
            DP_RESULT:
            begin
                done_next    = 1'b1;
                res_st_next  = ST_OK;
                res_occ_next = '0;
                res_val_next = '0;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (found_reg)
                        begin
                            res_occ_next = cnt_inc;
                        end
                        else if (full_reg)
                        begin
                            res_st_next = ST_FULL;
                        end
                        else
                        begin
                            res_occ_next = COUNT_W'(1);
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (!found_reg)
                        begin
                            res_st_next = ST_NOT_FOUND;
                        end
                        else if (hit_cnt_reg != COUNT_W'(1))
                        begin
                            res_occ_next = hit_cnt_reg - 1'b1;
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (found_reg)
                        begin
                            res_occ_next = hit_cnt_reg;
                        end
                        else
                        begin
                            res_st_next = ST_NOT_FOUND;
                        end
                    end
                    CMD_READ_AT:
                    begin
                        if (pos_ok)
                        begin
                            res_occ_next = rd_cnt_reg;
                            res_val_next = rd_val_reg;
                        end
                        else
                        begin
                            res_st_next = ST_BAD_POS;
                        end
                    end
                    default: ;
                endcase
                res_dst_next = (used_w > DW'(DIST_MAX)) ? DIST_MAX : used_w[DIST_W-1:0];
                res_tot_next = (total_w > SW'(TOTAL_MAX)) ? TOTAL_MAX
                                                          : total_w[TOTAL_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= 1'b0;
            cmd_reg       <= CMD_ADD;
            used_reg      <= '0;
            total_reg     <= '0;
            ptr_reg       <= '0;
            tag_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            ins_found_reg <= 1'b0;
            full_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            order_reg     <= order_next;
            cmd_reg       <= cmd_next;
            used_reg      <= used_next;
            total_reg     <= total_next;
            ptr_reg       <= ptr_next;
            tag_reg       <= tag_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            ins_found_reg <= ins_found_next;
            full_reg      <= full_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        pos_reg     <= pos_next;
        hit_reg     <= hit_next;
        hit_cnt_reg <= hit_cnt_next;
        ins_reg     <= ins_next;
        res_st_reg  <= res_st_next;
        res_occ_reg <= res_occ_next;
        res_val_reg <= res_val_next;
        res_dst_reg <= res_dst_next;
        res_tot_reg <= res_tot_next;
    end

    assign stat.cmd        = cmd_reg;
    assign stat.scan_done  = found_reg || ((ptr_reg >= used_reg) && !rd_vld_reg);
    assign stat.shift_done = !rd_vld_reg &&
                             (ptr_reg == ((cmd_reg == CMD_ADD) ? ins_reg : used_reg));
    assign stat.found      = found_reg;
    assign stat.full       = full_reg;
    assign stat.cnt_one    = (hit_cnt_reg == COUNT_W'(1));

    assign done           = done_reg;
    assign status         = res_st_reg;
    assign occurrences    = res_occ_reg;
    assign value_out      = res_val_reg;
    assign distinct_count = res_dst_reg;
    assign total_count    = res_tot_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_multiset_table.sv =====
// Sorted multiset table: a command is taken when start is high and busy low.
// Scanning the n entries held serves add, remove and lookup; an add that inserts and a
// remove that deletes then shift the later entries, one entry a cycle each. A read-at
// reads its position directly, with no scan.
// A new command is taken in the strobe cycle; the receiver cannot stall.
// Asynchronous active-low reset empties the table and sets ascending order.
`default_nettype none

module sorted_multiset_table
    import smt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 cmd,
    input  wire logic signed [VALUE_W-1:0]  value,
    input  wire logic [POS_W-1:0]           position,
    input  wire logic                       cfg_we,
    input  wire logic                       order_descending,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [COUNT_W-1:0]              occurrences,
    output logic signed [VALUE_W-1:0]       value_out,
    output logic [DIST_W-1:0]               distinct_count,
    output logic [TOTAL_W-1:0]              total_count
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    smt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    smt_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .stat             (stat),
        .cmd              (cmd),
        .value            (value),
        .position         (position),
        .cfg_we           (cfg_we),
        .order_descending (order_descending),
        .done             (done),
        .status           (status),
        .occurrences      (occurrences),
        .value_out        (value_out),
        .distinct_count   (distinct_count),
        .total_count      (total_count)
    );

endmodule

`default_nettype wire

// ===== rtl/smt_checker.sv =====
// Port-level checker for the sorted multiset table, bound to the top level.
// Depends on smt_pkg for the status codes and widths.
`default_nettype none

module smt_checker
    import smt_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic [1:0]         status,
    input wire logic [COUNT_W-1:0] occurrences,
    input wire logic [VALUE_W-1:0] value_out
);

    // an accepted word keeps the block busy until its result is out
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_end_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("command finished without a result");

    a_bad_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_BAD_POS)) |-> ((occurrences == '0) && (value_out == '0)))
        else $error("bad position result carries data");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ((status == ST_NOT_FOUND) || (status == ST_FULL))) |->
        (occurrences == '0))
        else $error("failed command reports a count");

endmodule

bind sorted_multiset_table smt_checker u_smt_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .occurrences (occurrences),
    .value_out   (value_out)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for sorted_multiset_table: command handshake, result strobe,
// order register. Needs smt_pkg and the RTL only; it predicts each result and compares
// it field by field.
module tb_top;
    import smt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 2 * DEPTH_DEF + 20;
    localparam int POOL_SIZE      = 20;
    localparam int REPEAT_ADDS    = 200;
    localparam int PHASE_WORDS    = 230;

    typedef struct {
        status_t            st;
        logic [COUNT_W-1:0] occ;
        logic [VALUE_W-1:0] vout;
        logic [DIST_W-1:0]  dcnt;
        logic [TOTAL_W-1:0] total;
    } bag_result_t;

    logic                      clk;
    logic                      rst_n            = 1'b0;
    logic                      start            = 1'b0;
    cmd_t                      cmd_r            = CMD_ADD;
    logic signed [VALUE_W-1:0] value_r          = '0;
    logic [POS_W-1:0]          pos_r            = '0;
    logic                      cfg_we           = 1'b0;
    logic                      order_descending = 1'b0;

    logic                      busy;
    logic                      done;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        occurrences;
    logic signed [VALUE_W-1:0] value_out;
    logic [DIST_W-1:0]         distinct_count;
    logic [TOTAL_W-1:0]        total_count;

    // Mirror of the table
    logic [VALUE_W-1:0] bag_val [SLOTS];
    logic [COUNT_W-1:0] bag_cnt [SLOTS];
    int                 bag_used;
    bit                 bag_desc;

    bag_result_t        expected_q [$];
    bag_result_t        head_r;
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    int  words_sent;
    int  results_checked;
    int  fail_count;
    int  order_writes;
    int  status_seen [4];
    int  burst_left;
    bit  steady;
    int  stall_cycles;

    sorted_multiset_table u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cmd              (cmd_r),
        .value            (value_r),
        .position         (pos_r),
        .cfg_we           (cfg_we),
        .order_descending (order_descending),
        .done             (done),
        .status           (status),
        .occurrences      (occurrences),
        .value_out        (value_out),
        .distinct_count   (distinct_count),
        .total_count      (total_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic int find_slot(logic [VALUE_W-1:0] v);
        for (int i = 0; i < bag_used; i++)
        begin
            if (bag_val[i] == v)
                return i;
        end
        return -1;
    endfunction

    function automatic bit ahead_of(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
        return bag_desc ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
    endfunction

    function automatic bag_result_t apply_to_bag(cmd_t c, logic [VALUE_W-1:0] v,
                                                 logic [POS_W-1:0] p);
        bag_result_t r;
        int          slot;
        int          ins;
        longint      sum;
        r.st   = ST_OK;
        r.occ  = '0;
        r.vout = '0;
        slot   = find_slot(v);
        case (c)
            CMD_ADD:
            begin
                if (slot >= 0)
                begin
                    if (bag_cnt[slot] != COUNT_MAX)
                        bag_cnt[slot]++;
                    r.occ = bag_cnt[slot];
                end
                else if (bag_used >= SLOTS)
                    r.st = ST_FULL;
                else
                begin
                    // stop at the first entry that does not sort ahead, even if unsorted
                    ins = 0;
                    while (ins < bag_used && ahead_of(bag_val[ins], v))
                        ins++;
                    for (int i = bag_used; i > ins; i--)
                    begin
                        bag_val[i] = bag_val[i-1];
                        bag_cnt[i] = bag_cnt[i-1];
                    end
                    bag_val[ins] = v;
                    bag_cnt[ins] = COUNT_W'(1);
                    bag_used++;
                    r.occ = COUNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (slot < 0)
                    r.st = ST_NOT_FOUND;
                else if (bag_cnt[slot] > 1)
                begin
                    bag_cnt[slot]--;
                    r.occ = bag_cnt[slot];
                end
                else
                begin
                    for (int i = slot; i + 1 < bag_used; i++)
                    begin
                        bag_val[i] = bag_val[i+1];
                        bag_cnt[i] = bag_cnt[i+1];
                    end
                    bag_used--;
                end
            end
            CMD_LOOKUP:
            begin
                if (slot >= 0)
                    r.occ = bag_cnt[slot];
                else
                    r.st = ST_NOT_FOUND;
            end
            default:
            begin
                if (p < bag_used)
                begin
                    r.vout = bag_val[p];
                    r.occ  = bag_cnt[p];
                end
                else
                    r.st = ST_BAD_POS;
            end
        endcase
        sum = 0;
        for (int i = 0; i < bag_used; i++)
            sum += bag_cnt[i];
        r.total = (sum > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(sum);
        r.dcnt  = (bag_used > DIST_MAX) ? DIST_MAX : DIST_W'(bag_used);
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result strobe with no command outstanding (status %0d)", status);
                fail_count++;
            end
            else
            begin
                head_r = expected_q.pop_front();
                results_checked++;
                status_seen[status]++;
                if (status !== head_r.st)
                begin
                    $error("status: expected %0d, got %0d", head_r.st, status);
                    fail_count++;
                end
                if (occurrences !== head_r.occ)
                begin
                    $error("occurrences: expected %0d, got %0d", head_r.occ, occurrences);
                    fail_count++;
                end
                if (value_out !== head_r.vout)
                begin
                    $error("value_out: expected %0d, got %0d",
                           $signed(head_r.vout), value_out);
                    fail_count++;
                end
                if (distinct_count !== head_r.dcnt)
                begin
                    $error("distinct_count: expected %0d, got %0d",
                           head_r.dcnt, distinct_count);
                    fail_count++;
                end
                if (total_count !== head_r.total)
                begin
                    $error("total_count: expected %0d, got %0d", head_r.total, total_count);
                    fail_count++;
                end
            end
        end
    end

    // Abort when neither side moves a word for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no handshake for %0d cycles, %0d results outstanding",
                   stall_cycles, expected_q.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- driving

    // Called at a rising edge. When steady or within a burst it returns at the accepting edge
    // with start still high, so the caller sends again or lowers start in the same step.
    task automatic put_word(input cmd_t c, input logic [VALUE_W-1:0] v,
                            input logic [POS_W-1:0] p);
        start   <= 1'b1;
        cmd_r   <= c;
        value_r <= v;
        pos_r   <= p;
        do @(posedge clk); while (busy !== 1'b0);
        expected_q.push_back(apply_to_bag(c, v, p));
        words_sent++;
        if (steady)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(30, 150)) @(posedge clk);
            else
                repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 8);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Every command yields a result, so an empty queue means the block is idle
    task automatic set_order(input bit desc);
        drain_results();
        cfg_we           <= 1'b1;
        order_descending <= desc;
        @(posedge clk);
        cfg_we   <= 1'b0;
        bag_desc  = desc;
        order_writes++;
    endtask

    function automatic logic [VALUE_W-1:0] fresh_value();
        logic [VALUE_W-1:0] v;
        v = $urandom;
        while (find_slot(v) >= 0)
            v = $urandom;
        return v;
    endfunction

    function automatic logic [VALUE_W-1:0] extreme_value();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h8000_0001;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 75 && bag_used > 0)
            return bag_val[$urandom_range(0, bag_used - 1)];
        if (r < 92)
            return $urandom;
        return extreme_value();
    endfunction

    function automatic void refill_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (i < 4)
                value_pool[i] = extreme_value();
            else if (i % 2 == 0)
                value_pool[i] = $urandom;
            else
                value_pool[i] = VALUE_W'($urandom_range(0, 40)) - 32'd20;
        end
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        put_word(CMD_LOOKUP,  32'd5, 6'd0);          // empty table
        put_word(CMD_REMOVE,  32'd5, 6'd0);
        put_word(CMD_READ_AT, 32'd0, 6'd0);
        put_word(CMD_READ_AT, 32'd0, 6'd63);
        put_word(CMD_ADD,     32'h7FFF_FFFF, 6'd0);
        put_word(CMD_ADD,     32'h8000_0000, 6'd0);
        put_word(CMD_ADD,     32'h0000_0000, 6'd0);
        put_word(CMD_ADD,     32'hFFFF_FFFF, 6'd0);
        put_word(CMD_ADD,     32'h0000_0000, 6'd0);
        put_word(CMD_ADD,     32'h0000_0001, 6'd0);
        for (int i = 0; i < 6; i++)
            put_word(CMD_READ_AT, 32'hFFFF_FFFF, POS_W'(i));
        put_word(CMD_LOOKUP,  32'h0000_0000, 6'd0);
        put_word(CMD_REMOVE,  32'h0000_0000, 6'd0);
        put_word(CMD_REMOVE,  32'h0000_0000, 6'd0);  // deletes the entry
        put_word(CMD_REMOVE,  32'h0000_0000, 6'd0);
        put_word(CMD_LOOKUP,  32'h0000_0000, 6'd0);
        put_word(CMD_REMOVE,  32'h7FFF_FFFF, 6'd0);
        put_word(CMD_REMOVE,  32'h8000_0000, 6'd0);
        put_word(CMD_READ_AT, 32'h0000_0000, 6'd0);
    endtask

    // Smallest value sits at the front in ascending order, so each bump is quick
    task automatic test_repeated_add();
        set_order(1'b0);
        steady = 1'b1;
        for (int i = 0; i < REPEAT_ADDS; i++)
            put_word(CMD_ADD, 32'h8000_0000, 6'd0);
        put_word(CMD_LOOKUP, 32'h8000_0000, 6'd0);
        put_word(CMD_REMOVE, 32'h8000_0000, 6'd0);
        put_word(CMD_ADD,    32'h8000_0000, 6'd0);
        steady = 1'b0;
    endtask

    task automatic test_table_full();
        logic [VALUE_W-1:0] v;
        while (bag_used < SLOTS)
        begin
            v = fresh_value();
            put_word(CMD_ADD, v, 6'd0);
        end
        v = fresh_value();
        put_word(CMD_ADD,     v, 6'd0);
        put_word(CMD_ADD,     bag_val[SLOTS - 1], 6'd0);
        put_word(CMD_READ_AT, 32'd0, 6'd63);
        put_word(CMD_READ_AT, 32'd0, 6'd0);
        put_word(CMD_LOOKUP,  bag_val[SLOTS / 2], 6'd0);
        put_word(CMD_REMOVE,  bag_val[SLOTS / 2], 6'd0);
        put_word(CMD_READ_AT, 32'd0, 6'd63);
        put_word(CMD_ADD,     v, 6'd0);
    endtask

    // Flip the order with entries held: nothing is re-sorted
    task automatic test_order_flip();
        set_order(1'b1);
        repeat (6)
            put_word(CMD_ADD, fresh_value(), 6'd0);
        for (int i = 0; i < 6; i++)
            put_word(CMD_READ_AT, 32'd0, POS_W'($urandom_range(0, bag_used - 1)));
        set_order(1'b0);
        repeat (4)
            put_word(CMD_ADD, fresh_value(), 6'd0);
        put_word(CMD_LOOKUP,  bag_val[0], 6'd0);
        put_word(CMD_READ_AT, 32'd0, 6'd0);
        put_word(CMD_READ_AT, 32'd0, POS_W'(bag_used - 1));
    endtask

    task automatic issue_random(input int phase);
        int   r;
        int   add_w;
        int   rem_w;
        logic [VALUE_W-1:0] v;
        logic [POS_W-1:0]   p;
        add_w = 35;
        rem_w = 30;
        if (phase == 2)
        begin
            add_w = 60;
            rem_w = 10;
        end
        else if (phase == 4)
        begin
            add_w = 15;
            rem_w = 55;
        end
        if (bag_used < 4)
            add_w += 20;
        r = $urandom_range(0, 99);
        p = POS_W'($urandom_range(0, 63));
        if (r < add_w)
            put_word(CMD_ADD, pick_value(), p);
        else if (r < add_w + rem_w)
        begin
            v = ($urandom_range(0, 9) < 7 && bag_used > 0)
                ? bag_val[$urandom_range(0, bag_used - 1)] : pick_value();
            put_word(CMD_REMOVE, v, p);
        end
        else if (r < add_w + rem_w + 15)
            put_word(CMD_LOOKUP, pick_value(), p);
        else
        begin
            if ($urandom_range(0, 9) < 7 && bag_used > 0)
                p = POS_W'($urandom_range(0, bag_used - 1));
            put_word(CMD_READ_AT, $urandom, p);
        end
    endtask

    task automatic test_random_mix();
        bit phase_order [6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
        for (int ph = 0; ph < 6; ph++)
        begin
            set_order(phase_order[ph]);
            refill_pool();
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // hold the sender until everything outstanding has come back
                if (ph == 3 && n == 140)
                    drain_results();
                issue_random(ph);
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        bag_used   = 0;
        bag_desc   = 1'b0;
        burst_left = 0;
        steady     = 1'b0;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_repeated_add();
        test_table_full();
        test_order_flip();
        test_random_mix();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d commands, %0d results checked, %0d order writes",
                 words_sent, results_checked, order_writes);
        $display("run: ok %0d, not found %0d, full %0d, bad position %0d, mismatches %0d",
                 status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_FULL],
                 status_seen[ST_BAD_POS], fail_count);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("tb_top: clean");
        else
        begin
            if (expected_q.size() != 0)
                $error("%0d results never arrived", expected_q.size());
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/smt_pkg.sv
rtl/smt_ctrl.sv
rtl/smt_dpath.sv
rtl/sorted_multiset_table.sv
rtl/smt_checker.sv
dv/tb_top.sv
